// ----- sv/ssmm_pkg.sv -----
package ssmm_pkg;

  localparam int unsigned MAX_SCAN_LENGTH = 4096;

  localparam int unsigned RANGE_W = 16;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned LEN_W   = $clog2(MAX_SCAN_LENGTH + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_SCAN_LENGTH);
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam int unsigned SUM_W   = RANGE_W + IDX_W;

  localparam logic [CFG_W-1:0] SCAN_LENGTH_RST = CFG_W'(360);
  localparam logic [RANGE_W-1:0] RANGE_EMPTY = '1;

  localparam int unsigned FRONT_LO_PCT = 42;
  localparam int unsigned FRONT_HI_PCT = 58;
  localparam int unsigned RIGHT_LO_PCT = 75;
  localparam int unsigned RIGHT_HI_PCT = 92;
  localparam int unsigned LEFT_LO_PCT  = 8;
  localparam int unsigned LEFT_HI_PCT  = 25;

  // Division by 100 of a length times a percentage is a multiplication by a
  // scaled reciprocal, exact for every product below 2**X_W.
  localparam longint unsigned PROD_MAX = longint'(MAX_SCAN_LENGTH) * RIGHT_HI_PCT;
  localparam int unsigned X_W = $clog2(PROD_MAX + 1);
  localparam int unsigned DIV_SH = X_W + 7;
  localparam longint unsigned DIV_M = ((64'd1 << DIV_SH) + 64'd99) / 64'd100;
  localparam int unsigned MUL_W = LEN_W + DIV_SH;

  localparam int unsigned BND_N  = 6;
  localparam int unsigned BNDI_W = $clog2(BND_N);

  localparam logic [BNDI_W-1:0] B_FLO = BNDI_W'(0);
  localparam logic [BNDI_W-1:0] B_FHI = BNDI_W'(1);
  localparam logic [BNDI_W-1:0] B_RLO = BNDI_W'(2);
  localparam logic [BNDI_W-1:0] B_RHI = BNDI_W'(3);
  localparam logic [BNDI_W-1:0] B_LLO = BNDI_W'(4);
  localparam logic [BNDI_W-1:0] B_LHI = BNDI_W'(5);

  localparam logic [DIV_SH-1:0] BND_K [BND_N] = '{
    DIV_SH'(FRONT_LO_PCT * DIV_M),
    DIV_SH'(FRONT_HI_PCT * DIV_M),
    DIV_SH'(RIGHT_LO_PCT * DIV_M),
    DIV_SH'(RIGHT_HI_PCT * DIV_M),
    DIV_SH'(LEFT_LO_PCT * DIV_M),
    DIV_SH'(LEFT_HI_PCT * DIV_M)
  };

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned QP_W    = $clog2(Q_DEPTH);
  localparam int unsigned QC_W    = $clog2(Q_DEPTH + 1);

  localparam int unsigned QUO_W  = RANGE_W;
  localparam int unsigned STEP_W = $clog2(QUO_W);

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               finite;
  } ssmm_in_t;

  typedef struct packed {
    logic [RANGE_W-1:0] front_min_mm;
    logic               front_empty;
    logic [RANGE_W-1:0] right_mean_mm;
    logic               right_empty;
    logic [RANGE_W-1:0] left_mean_mm;
    logic               left_empty;
  } ssmm_out_t;

  typedef struct packed {
    logic               last;
    logic               in_front;
    logic               in_right;
    logic               in_left;
    logic [RANGE_W-1:0] range_mm;
  } ssmm_item_t;

endpackage

// ----- sv/scan_sector_min_mean.sv -----
// Throughput: one range sample per cycle while the queue has room and no bound pass runs.
// After the last sample of a scan, the right mean and then the left mean are found
// and the result is registered in ST_OUT; the means share one 16-step radix-2 divider.
// While the divider works, the queue fills and further requests stall.
// Reset is asynchronous and active low; after reset and after every scan_length
// write, a pass computes the six window bounds in turn; requests stall meanwhile.
module scan_sector_min_mean (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ssmm_pkg::ssmm_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ssmm_pkg::ssmm_out_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import ssmm_pkg::*;

  localparam logic REG_SCAN_LENGTH = 1'b0;

  logic [CFG_W-1:0] scan_length_q;
  logic             cfg_wr;

  logic             q_push;
  ssmm_item_t       q_wdata;
  logic             q_full;
  logic             q_pop;
  ssmm_item_t       q_rdata;
  logic             q_empty;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SCAN_LENGTH);
  assign prdata = (paddr[2] == REG_SCAN_LENGTH) ? 32'(scan_length_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_length_q <= SCAN_LENGTH_RST;
    end else if (cfg_wr) begin
      scan_length_q <= pwdata[CFG_W-1:0];
    end
  end

  ssmm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .scan_length_i (scan_length_q),
    .cfg_wr_i      (cfg_wr),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  ssmm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .empty_o     (q_empty)
  );

  ssmm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sv/ssmm_fifo.sv -----
module ssmm_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ssmm_pkg::ssmm_item_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output ssmm_pkg::ssmm_item_t pop_data_o,
  output logic                 empty_o
);
  import ssmm_pkg::*;

  ssmm_item_t       mem_q [Q_DEPTH];
  logic [QP_W-1:0]  wr_ptr_q;
  logic [QP_W-1:0]  rd_ptr_q;
  logic [QC_W-1:0]  cnt_q;

  assign full_o     = (cnt_q == QC_W'(Q_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QP_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QP_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QC_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("Queue written while full.");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("Queue read while empty.");

endmodule

// ----- sv/ssmm_front.sv -----
module ssmm_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ssmm_pkg::CFG_W-1:0]  scan_length_i,
  input  logic                        cfg_wr_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ssmm_pkg::ssmm_in_t          in_data_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output ssmm_pkg::ssmm_item_t        q_data_o
);
  import ssmm_pkg::*;

  logic              pass_q;
  logic [BNDI_W-1:0] pcnt_q;
  logic [IDX_W-1:0]  bnd_q [BND_N];
  logic [IDX_W-1:0]  idx_q;

  logic [LEN_W-1:0]  len_eff;
  logic [IDX_W-1:0]  len_m1;
  logic [MUL_W-1:0]  prod;
  logic [IDX_W-1:0]  bound;
  logic              last;

  always_comb begin
    if (scan_length_i == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(scan_length_i) > MAX_SCAN_LENGTH) begin
      len_eff = LEN_W'(MAX_SCAN_LENGTH);
    end else begin
      len_eff = LEN_W'(scan_length_i);
    end
  end

  assign len_m1 = IDX_W'(len_eff - LEN_W'(1));
  assign prod   = MUL_W'(len_eff) * MUL_W'(BND_K[pcnt_q]);
  assign bound  = prod[DIV_SH +: IDX_W];
  assign last   = (idx_q >= len_m1);

  assign in_stall_o = pass_q | q_full_i;
  assign q_push_o   = in_valid_i & ~in_stall_o;

  always_comb begin
    q_data_o.last     = last;
    q_data_o.in_front = in_data_i.finite && (idx_q >= bnd_q[B_FLO]) && (idx_q < bnd_q[B_FHI]);
    q_data_o.in_right = in_data_i.finite && (idx_q >= bnd_q[B_RLO]) && (idx_q < bnd_q[B_RHI]);
    q_data_o.in_left  = in_data_i.finite && (idx_q >= bnd_q[B_LLO]) && (idx_q < bnd_q[B_LHI]);
    q_data_o.range_mm = in_data_i.range_mm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= 1'b1;
      pcnt_q <= '0;
      idx_q  <= '0;
    end else begin
      if (cfg_wr_i) begin
        pass_q <= 1'b1;
        pcnt_q <= '0;
      end else if (pass_q) begin
        if (pcnt_q == BNDI_W'(BND_N - 1)) begin
          pass_q <= 1'b0;
        end else begin
          pcnt_q <= pcnt_q + BNDI_W'(1);
        end
      end
      if (q_push_o) begin
        idx_q <= last ? '0 : idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pass_q) begin
      bnd_q[pcnt_q] <= bound;
    end
  end

  a_cfg_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr_i |=> in_stall_o) else $error("Request taken before window bounds were ready.");

endmodule

// ----- sv/ssmm_div.sv -----
module ssmm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ssmm_pkg::SUM_W-1:0]  dividend_i,
  input  logic [ssmm_pkg::CNT_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [ssmm_pkg::QUO_W-1:0]  quotient_o
);
  import ssmm_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  rem_q;
  logic [QUO_W-1:0]  shf_q;
  logic [CNT_W-1:0]  dvs_q;

  logic [CNT_W:0]    trial;
  logic              ge;

  assign trial      = {rem_q, shf_q[QUO_W-1]};
  assign ge         = (trial >= {1'b0, dvs_q});
  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = shf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(QUO_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= CNT_W'(dividend_i[SUM_W-1:QUO_W]);
      shf_q <= dividend_i[QUO_W-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
      shf_q <= {shf_q[QUO_W-2:0], ge};
    end
  end

endmodule

// ----- sv/ssmm_back.sv -----
module ssmm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  ssmm_pkg::ssmm_item_t q_data_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ssmm_pkg::ssmm_out_t  out_data_o
);
  import ssmm_pkg::*;

  localparam logic [2:0] ST_ACC = 3'd0;
  localparam logic [2:0] ST_RS  = 3'd1;
  localparam logic [2:0] ST_RW  = 3'd2;
  localparam logic [2:0] ST_LS  = 3'd3;
  localparam logic [2:0] ST_LW  = 3'd4;
  localparam logic [2:0] ST_OUT = 3'd5;

  logic [2:0]         state_q, state_d;

  logic [RANGE_W-1:0] min_q, min_d;
  logic               seen_q, seen_d;
  logic [SUM_W-1:0]   rsum_q, rsum_d;
  logic [CNT_W-1:0]   rcnt_q, rcnt_d;
  logic [SUM_W-1:0]   lsum_q, lsum_d;
  logic [CNT_W-1:0]   lcnt_q, lcnt_d;

  logic [RANGE_W-1:0] hmin_q;
  logic               hseen_q;
  logic [SUM_W-1:0]   hrsum_q;
  logic [CNT_W-1:0]   hrcnt_q;
  logic [SUM_W-1:0]   hlsum_q;
  logic [CNT_W-1:0]   hlcnt_q;
  logic [RANGE_W-1:0] rmean_q;
  logic [RANGE_W-1:0] lmean_q;

  logic               out_valid_q;
  ssmm_out_t          out_q;

  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [SUM_W-1:0]   div_num;
  logic [CNT_W-1:0]   div_den;
  logic [QUO_W-1:0]   div_quo;
  logic               out_load;

  assign q_pop_o     = (state_q == ST_ACC) && !q_empty_i;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign div_start = ((state_q == ST_RS) && (hrcnt_q != '0)) ||
                     ((state_q == ST_LS) && (hlcnt_q != '0));
  assign div_num   = (state_q == ST_RS) ? hrsum_q : hlsum_q;
  assign div_den   = (state_q == ST_RS) ? hrcnt_q : hlcnt_q;

  always_comb begin
    min_d  = (q_data_i.in_front && (q_data_i.range_mm < min_q)) ? q_data_i.range_mm : min_q;
    seen_d = seen_q | q_data_i.in_front;
    rsum_d = rsum_q + (q_data_i.in_right ? SUM_W'(q_data_i.range_mm) : '0);
    rcnt_d = rcnt_q + CNT_W'(q_data_i.in_right);
    lsum_d = lsum_q + (q_data_i.in_left ? SUM_W'(q_data_i.range_mm) : '0);
    lcnt_d = lcnt_q + CNT_W'(q_data_i.in_left);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACC: begin
        if (q_pop_o && q_data_i.last) begin
          state_d = ST_RS;
        end
      end
      ST_RS:  state_d = (hrcnt_q != '0) ? ST_RW : ST_LS;
      ST_RW:  state_d = div_done ? ST_LS : ST_RW;
      ST_LS:  state_d = (hlcnt_q != '0) ? ST_LW : ST_OUT;
      ST_LW:  state_d = div_done ? ST_OUT : ST_LW;
      ST_OUT: state_d = out_load ? ST_ACC : ST_OUT;
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      min_q       <= RANGE_EMPTY;
      seen_q      <= 1'b0;
      rsum_q      <= '0;
      rcnt_q      <= '0;
      lsum_q      <= '0;
      lcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        if (q_data_i.last) begin
          min_q  <= RANGE_EMPTY;
          seen_q <= 1'b0;
          rsum_q <= '0;
          rcnt_q <= '0;
          lsum_q <= '0;
          lcnt_q <= '0;
        end else begin
          min_q  <= min_d;
          seen_q <= seen_d;
          rsum_q <= rsum_d;
          rcnt_q <= rcnt_d;
          lsum_q <= lsum_d;
          lcnt_q <= lcnt_d;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_data_i.last) begin
      hmin_q  <= min_d;
      hseen_q <= seen_d;
      hrsum_q <= rsum_d;
      hrcnt_q <= rcnt_d;
      hlsum_q <= lsum_d;
      hlcnt_q <= lcnt_d;
    end
    if ((state_q == ST_RS) && (hrcnt_q == '0)) begin
      rmean_q <= RANGE_EMPTY;
    end else if ((state_q == ST_RW) && div_done) begin
      rmean_q <= div_quo;
    end
    if ((state_q == ST_LS) && (hlcnt_q == '0)) begin
      lmean_q <= RANGE_EMPTY;
    end else if ((state_q == ST_LW) && div_done) begin
      lmean_q <= div_quo;
    end
    if (out_load) begin
      out_q.front_min_mm  <= hmin_q;
      out_q.front_empty   <= ~hseen_q;
      out_q.right_mean_mm <= rmean_q;
      out_q.right_empty   <= (hrcnt_q == '0);
      out_q.left_mean_mm  <= lmean_q;
      out_q.left_empty    <= (hlcnt_q == '0);
    end
  end

  ssmm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("Divider started while busy.");

  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_RW || state_q == ST_LW))
    else $error("Divider finished with no one waiting.");

endmodule

// ----- test/scan_sector_min_mean_tb.sv -----
module scan_sector_min_mean_tb;
  import ssmm_pkg::*;

  localparam logic [2:0] SCAN_LENGTH_ADDR = 3'd0;
  localparam logic [2:0] UNUSED_ADDR      = 3'd4;
  localparam int unsigned SETTLE_CYCLES   = 60;

  typedef enum logic [1:0] {STALL_NONE, STALL_SOME, STALL_HOLD} stall_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  ssmm_in_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  ssmm_out_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ssmm_in_t  sample_q[$];
  ssmm_out_t scan_stats_q[$];
  int unsigned mismatch_count = 0;

  logic [CFG_W-1:0]   scan_len_cfg = SCAN_LENGTH_RST;
  int unsigned        scan_pos = 0;
  logic [RANGE_W-1:0] front_low = RANGE_EMPTY;
  logic               front_hit = 1'b0;
  int unsigned        right_total = 0;
  int unsigned        right_n = 0;
  int unsigned        left_total = 0;
  int unsigned        left_n = 0;

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  scan_sector_min_mean dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic ssmm_in_t range_sample(logic [RANGE_W-1:0] range_mm, logic finite);
    ssmm_in_t s;
    s.range_mm = range_mm;
    s.finite = finite;
    return s;
  endfunction

  function automatic ssmm_in_t random_sample();
    logic [RANGE_W-1:0] r;
    case ($urandom_range(0, 7))
      0: r = '0;
      1: r = RANGE_EMPTY;
      default: r = RANGE_W'($urandom_range(0, 65535));
    endcase
    return range_sample(r, $urandom_range(0, 4) != 0);
  endfunction

  function automatic void add_sample(ssmm_in_t s);
    sample_q.insert(sample_q.size(), s);
  endfunction

  function automatic int unsigned effective_length();
    if (scan_len_cfg == 0) return 1;
    if (scan_len_cfg > MAX_SCAN_LENGTH) return MAX_SCAN_LENGTH;
    return 32'(scan_len_cfg);
  endfunction

  function automatic bit in_sector(int unsigned idx, int unsigned len, int unsigned lo_pct,
                                   int unsigned hi_pct);
    return idx >= len * lo_pct / 100 && idx < len * hi_pct / 100;
  endfunction

  function automatic void accumulate_sample(ssmm_in_t s);
    int unsigned len;
    int unsigned idx;
    ssmm_out_t stats;
    len = effective_length();
    idx = scan_pos;
    if (s.finite) begin
      if (in_sector(idx, len, FRONT_LO_PCT, FRONT_HI_PCT)) begin
        if (s.range_mm < front_low) front_low = s.range_mm;
        front_hit = 1'b1;
      end
      if (in_sector(idx, len, RIGHT_LO_PCT, RIGHT_HI_PCT)) begin
        right_total += s.range_mm;
        right_n++;
      end
      if (in_sector(idx, len, LEFT_LO_PCT, LEFT_HI_PCT)) begin
        left_total += s.range_mm;
        left_n++;
      end
    end
    if (idx + 1 < len) begin
      scan_pos = idx + 1;
    end else begin
      stats.front_min_mm  = front_hit ? front_low : RANGE_EMPTY;
      stats.front_empty   = !front_hit;
      stats.right_mean_mm = (right_n != 0) ? RANGE_W'(right_total / right_n) : RANGE_EMPTY;
      stats.right_empty   = (right_n == 0);
      stats.left_mean_mm  = (left_n != 0) ? RANGE_W'(left_total / left_n) : RANGE_EMPTY;
      stats.left_empty    = (left_n == 0);
      scan_stats_q.insert(scan_stats_q.size(), stats);
      scan_pos = 0;
      front_low = RANGE_EMPTY;
      front_hit = 1'b0;
      right_total = 0;
      right_n = 0;
      left_total = 0;
      left_n = 0;
    end
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_stats(ssmm_out_t got);
    ssmm_out_t want;
    if (scan_stats_q.size() == 0) begin
      report_mismatch("result with no scan pending");
    end else begin
      want = scan_stats_q.pop_front();
      if (got.front_min_mm !== want.front_min_mm)
        report_mismatch($sformatf("front_min_mm %0d, expected %0d",
                                  got.front_min_mm, want.front_min_mm));
      if (got.front_empty !== want.front_empty)
        report_mismatch($sformatf("front_empty %0b, expected %0b",
                                  got.front_empty, want.front_empty));
      if (got.right_mean_mm !== want.right_mean_mm)
        report_mismatch($sformatf("right_mean_mm %0d, expected %0d",
                                  got.right_mean_mm, want.right_mean_mm));
      if (got.right_empty !== want.right_empty)
        report_mismatch($sformatf("right_empty %0b, expected %0b",
                                  got.right_empty, want.right_empty));
      if (got.left_mean_mm !== want.left_mean_mm)
        report_mismatch($sformatf("left_mean_mm %0d, expected %0d",
                                  got.left_mean_mm, want.left_mean_mm));
      if (got.left_empty !== want.left_empty)
        report_mismatch($sformatf("left_empty %0b, expected %0b",
                                  got.left_empty, want.left_empty));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (in_valid_i) accumulate_sample(in_data_i);
      if (gap_left != 0 || sample_q.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i <= sample_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_stats(out_data_o);
      if (stall_left == 0) begin
        stall_left <= $urandom_range(1, 20);
        stall_mode <= stall_mode_e'($urandom_range(0, 2));
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        STALL_NONE: out_stall_i <= 1'b0;
        STALL_SOME: out_stall_i <= ($urandom_range(0, 2) == 0);
        default:    out_stall_i <= 1'b1;
      endcase
    end
  end

  task automatic settle();
    do begin
      @(negedge clk_i);
    end while (sample_q.size() != 0 || in_valid_i || scan_stats_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == SCAN_LENGTH_ADDR) scan_len_cfg = data[CFG_W-1:0];
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) add_sample(random_sample());
  endtask

  initial begin
    int unsigned new_len;
    int unsigned eff_len;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset length, then a shortened length that ends the scan in progress.
    queue_random(460);
    settle();
    apb_write(SCAN_LENGTH_ADDR, 32'd50);
    queue_random(51);
    settle();

    // A length of zero behaves as one sample per scan.
    apb_write(SCAN_LENGTH_ADDR, 32'd0);
    add_sample(range_sample(RANGE_EMPTY, 1'b1));
    add_sample(range_sample(16'd0, 1'b0));
    settle();

    apb_write(SCAN_LENGTH_ADDR, 32'd13);
    add_sample(range_sample(16'd1234, 1'b1));
    add_sample(range_sample(RANGE_EMPTY, 1'b1));
    add_sample(range_sample(16'd65533, 1'b1));
    add_sample(range_sample(16'd0, 1'b1));
    add_sample(range_sample(16'd0, 1'b1));
    add_sample(range_sample(RANGE_EMPTY, 1'b1));
    add_sample(range_sample(16'd0, 1'b0));
    add_sample(range_sample(16'd0, 1'b1));
    add_sample(range_sample(16'd0, 1'b1));
    add_sample(range_sample(16'd0, 1'b1));
    add_sample(range_sample(RANGE_EMPTY, 1'b1));
    add_sample(range_sample(16'd1, 1'b1));
    add_sample(range_sample(16'd0, 1'b0));
    settle();
    apb_write(UNUSED_ADDR, $urandom());

    // A length above the maximum acts as the maximum over the left window,
    // and a length of one then ends the scan at the next sample.
    apb_write(SCAN_LENGTH_ADDR, 32'h1FFF);
    queue_random(1100);
    settle();
    apb_write(SCAN_LENGTH_ADDR, 32'd1);
    queue_random(1);
    settle();

    repeat (10) begin
      new_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
      eff_len = (new_len == 0) ? 1 : new_len;
      apb_write(SCAN_LENGTH_ADDR, {19'($urandom()), 13'(new_len)});
      if ($urandom_range(0, 3) == 0) apb_write(UNUSED_ADDR, $urandom());
      queue_random(eff_len * $urandom_range(1, 3) +
                   (($urandom_range(0, 3) == 0) ? $urandom_range(1, eff_len) : 0));
      settle();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- scan_sector_min_mean.f -----
sv/ssmm_pkg.sv
sv/ssmm_fifo.sv
sv/ssmm_front.sv
sv/ssmm_div.sv
sv/ssmm_back.sv
sv/scan_sector_min_mean.sv
test/scan_sector_min_mean_tb.sv
